FILE: rtl/core/reorder_receiver_with_ack_assert.svh
// Assertion macros used by the reorder receiver datapath.
`ifndef REORDER_RECEIVER_WITH_ACK_ASSERT_SVH
`define REORDER_RECEIVER_WITH_ACK_ASSERT_SVH
`ifndef SYNTH
`define RRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rra assertion failed");
`define RRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rra assertion failed");
`else
`define RRA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RRA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/rra_pkg.sv
// Shared types, codes and constants of the reorder receiver.
package rra_pkg;
  localparam int unsigned SlotsDef      = 15;
  localparam int unsigned MaxPayloadDef = 32;
  localparam int unsigned SeqW          = 4;
  localparam int unsigned LenW          = 6;
  localparam int unsigned CntW          = 6;
  localparam int unsigned CfgW          = 16;

  localparam logic [1:0] ReqPkt   = 2'd0;
  localparam logic [1:0] ReqTick  = 2'd1;
  localparam logic [1:0] ReqStart = 2'd2;

  localparam logic KindData = 1'b0;
  localparam logic KindCtrl = 1'b1;

  localparam logic CfgReqMsg  = 1'b0;
  localparam logic CfgTimeout = 1'b1;

  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChE = 8'h45;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChK = 8'h4b;

  localparam logic [7:0]  ReqMsgRst  = 8'd48;
  localparam logic [15:0] TimeoutRst = 16'd1000;
  localparam logic [3:0]  CtlBytes   = 4'd5;

  typedef struct packed {
    logic byte_en;
    logic tick_en;
    logic finish;
    logic chk;
    logic rd;
    logic cap;
    logic load_word;
    logic load_ctl;
    logic ctl_get;
  } cmd_t;

  typedef struct packed {
    logic expire;
    logic io_zero;
    logic fin_ok;
    logic fin_drain;
    logic slot_ready;
    logic slot_empty;
    logic word_full;
    logic slot_done;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] ctl_word(logic [7:0] b1, logic [7:0] b2,
                                           logic [7:0] b3, logic [7:0] b4);
    logic [7:0] chk;
    chk = b1 ^ b2 ^ b3 ^ b4;
    return {24'd0, b4, b3, b2, b1, chk};
  endfunction
endpackage

FILE: rtl/core/rra_ctrl.sv
// Sequencing state machine of the reorder receiver.
module rra_ctrl import rra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_acc_i,
  input  logic [1:0] req_type_i,
  input  logic       end_of_packet_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       in_stall_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SFin  = 3'd1;
  localparam logic [2:0] SChk  = 3'd2;
  localparam logic [2:0] SRd   = 3'd3;
  localparam logic [2:0] SCap  = 3'd4;
  localparam logic [2:0] SEmit = 3'd5;
  localparam logic [2:0] SGet  = 3'd6;
  localparam logic [2:0] SAck  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       idle;

  assign idle       = (state_q == SIdle);
  assign in_stall_o = !idle;

  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_en   = idle && in_acc_i && (req_type_i == ReqPkt);
    cmd_o.tick_en   = idle && in_acc_i && (req_type_i == ReqTick);
    cmd_o.finish    = (state_q == SFin);
    cmd_o.chk       = (state_q == SChk);
    cmd_o.rd        = (state_q == SRd);
    cmd_o.cap       = (state_q == SCap);
    cmd_o.load_word = (state_q == SEmit) && sts_i.out_free;
    cmd_o.load_ctl  = ((state_q == SGet) || (state_q == SAck)) && sts_i.out_free;
    cmd_o.ctl_get   = (state_q == SGet);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (in_acc_i) begin
          case (req_type_i)
            ReqPkt:   if (end_of_packet_i) state_d = SFin;
            ReqTick:  if (sts_i.expire) state_d = sts_i.io_zero ? SGet : SAck;
            ReqStart: state_d = SGet;
            default:  state_d = SIdle;
          endcase
        end
      end
      SFin: begin
        if (!sts_i.fin_ok) state_d = SIdle;
        else state_d = sts_i.fin_drain ? SChk : SAck;
      end
      SChk: begin
        if (!sts_i.slot_ready) state_d = SAck;
        else state_d = sts_i.slot_empty ? SChk : SRd;
      end
      SRd:  state_d = SCap;
      SCap: state_d = sts_i.word_full ? SEmit : SRd;
      SEmit: begin
        if (sts_i.out_free) state_d = sts_i.slot_done ? SChk : SRd;
      end
      SGet, SAck: begin
        if (sts_i.out_free) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

FILE: rtl/core/rra_dp.sv
// Datapath of the reorder receiver: staging, slot store, timer and output register.
`include "reorder_receiver_with_ack_assert.svh"
module rra_dp import rra_pkg::*; #(
  parameter int unsigned Slots      = SlotsDef,
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic [7:0]      rx_byte_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [63:0]     data_word_o,
  output logic [3:0]      byte_count_o,
  output logic            last_o
);
  localparam int unsigned StageMax = MaxPayload + 3;
  localparam int unsigned SlotIdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned Depth    = Slots * MaxPayload;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]          b0_q, seq_q, tot_q, xor_q;
  logic [CntW-1:0]     cnt_q;
  logic                ovf_q;
  logic [Slots-1:0]    valid_q, valid_d;
  logic [LenW-1:0]     len_q [Slots];
  logic [SeqW-1:0]     io_q, total_q;
  logic [15:0]         tmr_q, tmo_q;
  logic                armed_q;
  logic [7:0]          req_msg_q;
  logic [LenW-1:0]     off_q, cur_len_q;
  logic [3:0]          k_q;
  logic [63:0]         word_q;
  logic [7:0]          rd_q;
  logic [7:0]          slot_mem [Depth];
  logic                out_valid_q, kind_q, last_q;
  logic [63:0]         data_q;
  logic [3:0]          bcnt_q;

  logic [SlotIdxW-1:0] seq_idx, io_idx;
  logic                seq_in_slots, wr_ok, pay_wr, good, first;
  logic [SeqW-1:0]     tot_sat, total_new;
  logic [AddrW-1:0]    wr_addr, rd_addr;
  logic [15:0]         tmr_inc, limit;
  logic                out_free;
  logic [63:0]         ctl_data;

  assign seq_idx      = SlotIdxW'(seq_q[SeqW-1:0] - SeqW'(1));
  assign io_idx       = SlotIdxW'(io_q);
  assign seq_in_slots = (seq_q != 8'd0) && (seq_q <= 8'(Slots));
  assign wr_ok        = seq_in_slots &&
                        (!valid_q[seq_idx] || ((seq_q == 8'd1) && (io_q == '0)));
  assign pay_wr       = cmd_i.byte_en && (cnt_q >= CntW'(3)) &&
                        (cnt_q < CntW'(StageMax)) && wr_ok;
  assign wr_addr      = AddrW'(seq_idx) * AddrW'(MaxPayload) + AddrW'(cnt_q - CntW'(3));
  assign rd_addr      = AddrW'(io_idx) * AddrW'(MaxPayload) + AddrW'(off_q);

  assign good      = !ovf_q && (cnt_q >= CntW'(3)) && (xor_q == b0_q);
  assign first     = good && (seq_q == 8'd1) && (io_q == '0);
  assign tot_sat   = (tot_q > 8'(Slots)) ? SeqW'(Slots) : tot_q[SeqW-1:0];
  assign total_new = first ? tot_sat : total_q;

  assign tmr_inc  = tmr_q + 16'd1;
  assign limit    = (tmo_q == 16'd0) ? 16'd1 : tmo_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ctl_data = cmd_i.ctl_get ? ctl_word(ChG, ChE, ChT, req_msg_q)
                                  : ctl_word(ChA, ChC, ChK, 8'(io_q));

  always_comb begin
    sts_o            = '0;
    sts_o.expire     = armed_q && (tmr_inc >= limit);
    sts_o.io_zero    = (io_q == '0);
    sts_o.fin_ok     = good && (seq_q != 8'd0) && (seq_q <= 8'(total_new));
    sts_o.fin_drain  = (seq_q == 8'(io_q) + 8'd1);
    sts_o.slot_ready = (io_q < total_q) && valid_q[io_idx];
    sts_o.slot_empty = (len_q[io_idx] == '0);
    sts_o.word_full  = (k_q == 4'd7) || (LenW'(off_q + LenW'(1)) == cur_len_q);
    sts_o.slot_done  = (off_q == cur_len_q);
    sts_o.out_free   = out_free;
  end

  always_comb begin
    valid_d = first ? '0 : valid_q;
    if (sts_o.fin_ok) valid_d[seq_idx] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (pay_wr) begin
      slot_mem[wr_addr] <= rx_byte_i;
    end
    if (cmd_i.rd) begin
      rd_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_en && (cnt_q == CntW'(0))) b0_q  <= rx_byte_i;
    if (cmd_i.byte_en && (cnt_q == CntW'(1))) seq_q <= rx_byte_i;
    if (cmd_i.byte_en && (cnt_q == CntW'(2))) tot_q <= rx_byte_i;
    if (cmd_i.finish && sts_o.fin_ok && (!valid_q[seq_idx] || first)) begin
      len_q[seq_idx] <= LenW'(cnt_q - CntW'(3));
    end
    if (cmd_i.chk) begin
      cur_len_q <= len_q[io_idx];
      off_q     <= '0;
      k_q       <= '0;
      word_q    <= '0;
    end else if (cmd_i.cap) begin
      word_q[{k_q[2:0], 3'b000} +: 8] <= rd_q;
      off_q <= LenW'(off_q + LenW'(1));
      k_q   <= k_q + 4'd1;
    end else if (cmd_i.load_word) begin
      word_q <= '0;
      k_q    <= '0;
    end
    if (cmd_i.load_word) begin
      kind_q <= KindData;
      data_q <= word_q;
      bcnt_q <= k_q;
      last_q <= 1'b0;
    end else if (cmd_i.load_ctl) begin
      kind_q <= KindCtrl;
      data_q <= ctl_data;
      bcnt_q <= CtlBytes;
      last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      xor_q       <= '0;
      valid_q     <= '0;
      io_q        <= '0;
      total_q     <= '0;
      tmr_q       <= '0;
      armed_q     <= 1'b0;
      req_msg_q   <= ReqMsgRst;
      tmo_q       <= TimeoutRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CfgReqMsg)) req_msg_q <= cfg_wdata_i[7:0];
      if (cfg_we_i && (cfg_idx_i == CfgTimeout)) tmo_q <= cfg_wdata_i;
      if (cmd_i.byte_en) begin
        if (cnt_q < CntW'(StageMax)) begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q != CntW'(0)) xor_q <= xor_q ^ rx_byte_i;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        xor_q <= '0;
        if (first) total_q <= tot_sat;
        valid_q <= valid_d;
      end
      if ((cmd_i.chk && sts_o.slot_ready && sts_o.slot_empty) ||
          (cmd_i.load_word && (off_q == cur_len_q))) begin
        io_q <= io_q + SeqW'(1);
      end
      if (cmd_i.load_ctl) begin
        tmr_q   <= '0;
        armed_q <= 1'b1;
      end else if (cmd_i.tick_en && armed_q) begin
        tmr_q <= tmr_inc;
      end
      if (cmd_i.load_word || cmd_i.load_ctl) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign data_word_o  = data_q;
  assign byte_count_o = bcnt_q;
  assign last_o       = last_q;

  `RRA_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd_i.load_word || cmd_i.load_ctl, out_free)
  `RRA_ASSERT_IMP(a_io_le_total, clk_i, rst_ni, 1'b1, io_q <= total_q)
  `RRA_ASSERT_NXT(a_tmr_restart, clk_i, rst_ni, cmd_i.load_ctl, armed_q && (tmr_q == '0))
  `RRA_ASSERT_IMP(a_word_nonempty, clk_i, rst_ni, cmd_i.load_word, k_q != 4'd0)
endmodule

FILE: rtl/core/reorder_receiver_with_ack.sv
// Reorder receiver: takes packet bytes, stores packets by sequence, delivers in order, ACKs, sends GETs.
// Packet bytes, ticks and starts are accepted only while idle; the end-of-packet byte adds a check state.
// In-order delivery walks the slot memory read port: each payload byte is read and captured, each
// word is emitted, each slot and the end are checked, then the ACK is sent; input is stalled throughout.
// A result is held in an output register until taken; the sequencer stalls only when it must load another.
// Asynchronous active-low reset clears control state and valid bits; no memory clear pass.
module reorder_receiver_with_ack import rra_pkg::*; #(
  parameter int unsigned Slots      = SlotsDef,
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            end_of_packet_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [63:0]     data_word_o,
  output logic [3:0]      byte_count_o,
  output logic            last_o
);
  cmd_t cmd;
  sts_t sts;
  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  rra_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_acc_i        (in_acc),
    .req_type_i      (req_type_i),
    .end_of_packet_i (end_of_packet_i),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .in_stall_o      (in_stall_o)
  );

  rra_dp #(
    .Slots      (Slots),
    .MaxPayload (MaxPayload)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .data_word_o  (data_word_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o)
  );
endmodule

FILE: dv/reorder_receiver_with_ack_tb.sv
// Self-checking testbench for the reorder receiver: packet stimulus, in-model prediction.
module reorder_receiver_with_ack_tb;
  import rra_pkg::*;

  localparam int NSLOT = 15;
  localparam int MAXPL = 32;
  localparam int STAGE = MAXPL + 3;
  localparam longint LIMIT = 4000000;

  typedef struct packed {
    logic [1:0] rtype;
    logic [7:0] b;
    logic       eop;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CfgReqMsg;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = ReqPkt;
  logic [7:0] rx_byte_i = '0;
  logic end_of_packet_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic [63:0] data_word_o;
  logic [3:0] byte_count_o;
  logic last_o;

  reorder_receiver_with_ack dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  m_reqmsg;
  logic [15:0] m_timeout;
  logic [7:0]  stg [STAGE];
  int          stg_cnt;
  bit          stg_ovf;
  logic [7:0]  pay [NSLOT][MAXPL];
  int          plen [NSLOT];
  bit          pvalid [NSLOT];
  int          inord;
  int          total;
  logic [15:0] tcount;
  bit          tarmed;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   sender_idle_pct, recv_idle_pct;
  int   errors = 0;
  longint cycles = 0;

  function automatic void push_res(logic kind, logic [63:0] w, logic [3:0] c);
    res_t r;
    r.kind = kind; r.word = w; r.cnt = c; r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void push_ctl(logic [7:0] b1, b2, b3, b4);
    push_res(KindCtrl, {24'd0, b4, b3, b2, b1, b1 ^ b2 ^ b3 ^ b4}, CtlBytes);
  endfunction

  function automatic void push_ack();
    push_ctl(ChA, ChC, ChK, 8'(inord));
  endfunction

  function automatic int finish_packet();
    logic [7:0] x;
    int seq, tot, idx, n, off, k;
    logic [63:0] w;
    x = 0; n = 0;
    if (stg_ovf || stg_cnt < 3) return 0;
    for (int i = 1; i < stg_cnt; i++) x ^= stg[i];
    if (x != stg[0]) return 0;
    seq = stg[1];
    tot = stg[2];
    if (seq == 1 && inord == 0) begin
      total = tot > NSLOT ? NSLOT : tot;
      foreach (pvalid[i]) pvalid[i] = 0;
    end
    if (seq < 1 || seq > total) return 0;
    idx = seq - 1;
    if (!pvalid[idx]) begin
      for (int i = 0; i < stg_cnt - 3; i++) pay[idx][i] = stg[3 + i];
      plen[idx] = stg_cnt - 3;
      pvalid[idx] = 1;
    end
    if (seq == inord + 1) begin
      while (inord < total && pvalid[inord]) begin
        for (off = 0; off < plen[inord]; off += 8) begin
          k = (plen[inord] - off < 8) ? plen[inord] - off : 8;
          w = '0;
          for (int i = 0; i < k; i++) w[8*i +: 8] = pay[inord][off + i];
          push_res(KindData, w, 4'(k));
          n++;
        end
        inord++;
      end
    end
    push_ack();
    tarmed = 1; tcount = 0;
    return n + 1;
  endfunction

  function automatic void predict_request(req_t r);
    int n;
    int lim;
    n = 0;
    case (r.rtype)
      ReqPkt: begin
        if (stg_cnt < STAGE) begin
          stg[stg_cnt] = r.b;
          stg_cnt++;
        end else stg_ovf = 1;
        if (r.eop) begin
          n = finish_packet();
          stg_cnt = 0; stg_ovf = 0;
        end
      end
      ReqTick: begin
        if (tarmed) begin
          lim = m_timeout == 0 ? 1 : m_timeout;
          tcount = tcount + 16'd1;
          if (tcount >= lim) begin
            if (inord == 0) push_ctl(ChG, ChE, ChT, m_reqmsg);
            else push_ack();
            tarmed = 1; tcount = 0;
            n = 1;
          end
        end
      end
      ReqStart: begin
        push_ctl(ChG, ChE, ChT, m_reqmsg);
        tarmed = 1; tcount = 0;
        n = 1;
      end
      default: ;
    endcase
    if (n > 0) expected_results[$].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && in_stall_o)) begin
        if (in_valid_i) predict_request({req_type_i, rx_byte_i, end_of_packet_i});
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= r.rtype;
          rx_byte_i <= r.b;
          end_of_packet_i <= r.eop;
        end else in_valid_i <= 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d word=%h", kind_o, data_word_o);
        errors++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, kind_o); errors++;
        end
        if (data_word_o !== e.word) begin
          $error("data_word: expected %h actual %h", e.word, data_word_o); errors++;
        end
        if (byte_count_o !== e.cnt) begin
          $error("byte_count: expected %0d actual %0d", e.cnt, byte_count_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, last_o); errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void add_req(logic [1:0] t, logic [7:0] b, logic eop);
    req_t r;
    r.rtype = t; r.b = b; r.eop = eop;
    pending_reqs.push_back(r);
  endfunction

  // builds one packet; corrupt flips the checksum
  function automatic void add_packet(int seq, int tot, int len, bit corrupt);
    logic [7:0] bytes[$];
    logic [7:0] x;
    bytes.push_back(8'(seq));
    bytes.push_back(8'(tot));
    for (int i = 0; i < len; i++) bytes.push_back(8'($urandom_range(255)));
    x = 0;
    foreach (bytes[i]) x ^= bytes[i];
    if (corrupt) x ^= 8'(1 << $urandom_range(7));
    add_req(ReqPkt, x, 1'b0);
    foreach (bytes[i]) add_req(ReqPkt, bytes[i], i == bytes.size() - 1);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [CfgW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgReqMsg) m_reqmsg = v[7:0];
    else m_timeout = v;
  endtask

  task automatic random_message(int tot);
    int order[$];
    int lens[NSLOT + 3];
    for (int s = 1; s <= tot; s++) begin
      order.push_back(s);
      lens[s] = ($urandom_range(19) == 0) ? MAXPL : $urandom_range(0, 4);
    end
    order.shuffle();
    order.push_front(1);
    add_req(ReqStart, 8'($urandom), 1'($urandom));
    foreach (order[i]) begin
      int r;
      r = $urandom_range(99);
      if (r < 6) add_packet(order[i], tot, lens[order[i]], 1);
      else if (r < 10) add_req(ReqTick, 8'($urandom), 1'($urandom));
      else if (r < 12) add_req(2'd3, 8'($urandom), 1'($urandom));
      else if (r < 14) add_packet($urandom_range(16, 255), tot, 2, 0);
      add_packet(order[i], tot, lens[order[i]], 0);
    end
  endtask

  task automatic run_phase(int s_idle, int r_idle, int items);
    int base;
    sender_idle_pct = s_idle; recv_idle_pct = r_idle;
    base = pending_reqs.size();
    while (pending_reqs.size() - base < items) random_message($urandom_range(1, NSLOT + 2));
    for (int i = 0; i < 12; i++) add_req(ReqTick, 8'($urandom), 1'($urandom));
    wait_idle();
  endtask

  initial begin
    m_reqmsg = ReqMsgRst; m_timeout = TimeoutRst;
    stg_cnt = 0; stg_ovf = 0; inord = 0; total = 0; tcount = 0; tarmed = 0;
    foreach (pvalid[i]) pvalid[i] = 0;
    sender_idle_pct = 0; recv_idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and special cases
    write_cfg(CfgReqMsg, 16'd255);
    write_cfg(CfgTimeout, 16'd0);
    add_req(ReqTick, 8'h00, 1'b0);
    add_req(2'd3, 8'hff, 1'b1);
    add_req(ReqStart, 8'hff, 1'b1);
    add_req(ReqTick, 8'hff, 1'b1);
    add_req(ReqPkt, 8'h00, 1'b0);
    add_req(ReqPkt, 8'h00, 1'b1);
    add_packet(2, 255, 0, 0);
    add_packet(1, 255, 0, 0);
    add_packet(2, 3, 8, 0);
    add_packet(2, 3, 8, 0);
    add_packet(0, 3, 1, 0);
    wait_idle();
    for (int i = 0; i < 37; i++) add_req(ReqPkt, 8'($urandom), i == 36);
    add_packet(3, 3, MAXPL, 0);
    add_packet(4, 3, 1, 0);
    add_packet(1, 3, 0, 1);
    add_req(ReqTick, 8'h00, 1'b0);
    wait_idle();
    write_cfg(CfgReqMsg, 16'd0);
    write_cfg(CfgTimeout, 16'd3);

    run_phase(19, 48, 30);
    write_cfg(CfgTimeout, 16'd65535);
    write_cfg(CfgReqMsg, 16'($urandom_range(255)));
    run_phase(48, 19, 30);
    write_cfg(CfgTimeout, 16'd1);
    run_phase(0, 0, 30);

    if (errors == 0 && expected_results.size() == 0) $display("SCOREBOARD CLEAN");
    else begin
      if (expected_results.size() != 0)
        $error("%0d expected results never arrived", expected_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
